@@ rtl/lrb_pkg.sv @@
// Shared types and constants for the light range bisection block.
package lrb_pkg;

	localparam int DIST_W  = 24;
	localparam int COEF_W  = 24;
	localparam int DEN_W   = 56;
	localparam int ITER_W  = 7;
	localparam int THR_W   = 16;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
	localparam logic [STAT_W-1:0] ST_BEYOND    = 2'd1;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;

	localparam logic [1:0] REG_MAX_ITER = 2'd0;
	localparam logic [1:0] REG_FAR     = 2'd1;
	localparam logic [1:0] REG_THR     = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_SUM,
		S_DIV,
		S_DECIDE,
		S_DONE
	} state_t;

	// Request and reply between the sequencer and the divider.
	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DEN_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ rtl/lrb_mul.sv @@
// Registered 24 x 28 multiplier shared by all product terms.
module lrb_mul (
	input  logic        clk,
	input  logic [23:0] a,
	input  logic [27:0] b,
	output logic [51:0] p_q
);

	// One product per cycle, result registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

@@ rtl/lrb_div.sv @@
// Restoring divider: 2^(F+16) / den, one quotient bit per cycle.
module lrb_div #(
	parameter int LEVEL_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lrb_pkg::div_req_t req,
	output lrb_pkg::div_rsp_t rsp
);

	localparam int NUM_W = LEVEL_FRAC_BITS + 17;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int DW    = lrb_pkg::DEN_W;

	logic [NUM_W-1:0] num_q;
	logic [DW:0]      rem_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      shifted;
	logic             fits;

	assign shifted = {rem_q[DW-1:0], num_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= {1'b1, {(NUM_W-1){1'b0}}};
			rem_q  <= '0;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? shifted - {1'b0, den_q} : shifted;
			quot_q <= {quot_q[DW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ rtl/light_range_bisection.sv @@
// Top level: sequencer, config registers and bisection state.
//
//   channel  dir  handshake         payload
//   in       in   in_valid/ready    target_level accuracy const/linear/quad_coeff
//   out      out  out_valid/ready   distance status
//   cfg      in   cfg_we            cfg_index cfg_data
//
// Each level evaluation runs the product states M1 to M4 on the shared
// multiplier, a sum state, the divider (skipped when the denominator is at
// or below the threshold) and a decision state; an item takes one evaluation
// for the far limit and one per bisection step.
// Reset is asynchronous and clears control; config registers take their reset values.
// The result waits in output registers; in_ready stays low until it is taken.
module light_range_bisection #(
	parameter int LEVEL_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [16:0] target_level,
	input  logic [16:0] accuracy,
	input  logic [23:0] const_coeff,
	input  logic [23:0] linear_coeff,
	input  logic [23:0] quad_coeff,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] distance,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int DW = lrb_pkg::DEN_W;
	localparam logic [DW-1:0] DEN_MAX = {DW{1'b1}};
	localparam logic [DW-1:0] ONE = DW'(1) << LEVEL_FRAC_BITS;

	lrb_pkg::state_t state_q, state_d;

	logic [6:0]  max_iter_q;
	logic [23:0] far_q;
	logic [15:0] thr_q;

	logic [16:0] tgt_q, acc_q;
	logic [23:0] c_q, l_q, q_q;
	logic [23:0] lo_q, hi_q, d_q;
	logic [6:0]  n_q;
	logic        far_chk_q;
	logic [19:0] d2_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] lvl_q;
	logic [23:0] dist_q;
	logic [1:0]  stat_q;
	logic        out_valid_q;

	logic [23:0] mul_a;
	logic [27:0] mul_b;
	logic [51:0] mul_p;
	lrb_pkg::div_req_t div_req;
	lrb_pkg::div_rsp_t div_rsp;

	logic [32:0] tgt_div10;
	logic [16:0] acc_adj;
	logic [17:0] band_hi;
	logic signed [18:0] band_lo;
	logic [DW-1:0] thr_use;
	logic [DW-1:0] lvl_div;
	logic [DW:0]   sum_tmp;
	logic [DW-1:0] den_sum;
	logic [23:0]   mid;
	logic          is_low, is_high;

	lrb_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));
	lrb_div #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= 7'd32;
			far_q      <= 24'd10240000;
			thr_q      <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrb_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[6:0];
				lrb_pkg::REG_FAR:      far_q      <= cfg_data;
				lrb_pkg::REG_THR:      thr_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Band edges; target/10 by reciprocal multiply, exact for 17-bit targets
	assign tgt_div10 = 33'(tgt_q) * 33'd52429;
	assign acc_adj = (tgt_q != '0 && acc_q >= tgt_q) ? {3'b0, tgt_div10[32:19]} : acc_q;
	assign band_hi = {1'b0, tgt_q} + {1'b0, acc_q};
	assign band_lo = $signed({2'b0, tgt_q}) - $signed({2'b0, acc_q});
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);

	// Accuracy rescaled to 16 fraction bits serves as the far check threshold
	assign thr_use = far_chk_q ? ((DW'(acc_q) << 16) >> LEVEL_FRAC_BITS) : DW'(thr_q);
	assign lvl_div = (div_rsp.quot > ONE) ? ONE : div_rsp.quot;
	assign is_high = lvl_q > DW'(band_hi);
	assign is_low  = !band_lo[18] && (lvl_q < DW'(band_lo[17:0]));

	// Full denominator: quad term plus c plus linear term, saturated
	assign sum_tmp = {1'b0, den_q} + {1'b0, DW'(c_q)} + (DW+1)'(mul_p >> 10);
	assign den_sum = (sum_tmp > {1'b0, DEN_MAX}) ? DEN_MAX : sum_tmp[DW-1:0];

	// Multiplier operand select
	always_comb begin
		mul_a = d_q;
		mul_b = {4'b0, d_q};
		unique case (state_q)
			lrb_pkg::S_M2: begin mul_a = q_q; mul_b = mul_p[47:20]; end
			lrb_pkg::S_M3: begin mul_a = q_q; mul_b = {8'b0, d2_q}; end
			lrb_pkg::S_M4: begin mul_a = l_q; mul_b = {4'b0, d_q}; end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrb_pkg::S_IDLE:   if (in_valid) state_d = lrb_pkg::S_PREP;
			lrb_pkg::S_PREP:   state_d = lrb_pkg::S_M1;
			lrb_pkg::S_M1:     state_d = lrb_pkg::S_M2;
			lrb_pkg::S_M2:     state_d = lrb_pkg::S_M3;
			lrb_pkg::S_M3:     state_d = lrb_pkg::S_M4;
			lrb_pkg::S_M4:     state_d = lrb_pkg::S_SUM;
			lrb_pkg::S_SUM:    state_d = (den_sum <= thr_use) ? lrb_pkg::S_DECIDE
			                                                  : lrb_pkg::S_DIV;
			lrb_pkg::S_DIV:    if (div_rsp.done) state_d = lrb_pkg::S_DECIDE;
			lrb_pkg::S_DECIDE: begin
				if (far_chk_q) begin
					if (is_high) state_d = lrb_pkg::S_DONE;
					else if (max_iter_q == '0) state_d = lrb_pkg::S_DONE;
					else state_d = lrb_pkg::S_M1;
				end else if (!is_low && !is_high) begin
					state_d = lrb_pkg::S_DONE;
				end else if (n_q + 7'd1 >= max_iter_q) begin
					state_d = lrb_pkg::S_DONE;
				end else begin
					state_d = lrb_pkg::S_M1;
				end
			end
			lrb_pkg::S_DONE:   if (!out_valid_q) state_d = lrb_pkg::S_IDLE;
			default:           state_d = lrb_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready      = (state_q == lrb_pkg::S_IDLE);
		div_req.start = (state_q == lrb_pkg::S_SUM) && !(den_sum <= thr_use);
		div_req.den   = den_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrb_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == lrb_pkg::S_DECIDE && state_d == lrb_pkg::S_DONE)
				out_valid_q <= 1'b1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			lrb_pkg::S_IDLE: begin
				if (in_valid) begin
					tgt_q <= target_level;
					acc_q <= accuracy;
					c_q   <= const_coeff;
					l_q   <= linear_coeff;
					q_q   <= quad_coeff;
				end
			end
			lrb_pkg::S_PREP: begin
				acc_q     <= acc_adj;
				far_chk_q <= 1'b1;
				d_q       <= far_q;
				lo_q      <= '0;
				hi_q      <= far_q;
				n_q       <= '0;
			end
			lrb_pkg::S_M1: ;
			lrb_pkg::S_M2: d2_q <= mul_p[19:0];
			lrb_pkg::S_M3: den_q <= DW'(mul_p);
			lrb_pkg::S_M4: den_q <= den_q + DW'(mul_p >> 20);
			lrb_pkg::S_SUM: begin
				// c + lin cannot reach 2^56; saturate the total
				den_q <= den_sum;
				lvl_q <= ONE;
			end
			lrb_pkg::S_DIV: if (div_rsp.done) lvl_q <= lvl_div;
			lrb_pkg::S_DECIDE: begin
				if (far_chk_q) begin
					far_chk_q <= 1'b0;
					dist_q    <= is_high ? far_q : far_q >> 1;
					stat_q    <= is_high ? lrb_pkg::ST_BEYOND : lrb_pkg::ST_EXHAUSTED;
					d_q       <= mid;
				end else begin
					n_q <= n_q + 7'd1;
					if (is_low) begin
						hi_q   <= d_q;
						dist_q <= lo_q + ((d_q - lo_q) >> 1);
						d_q    <= lo_q + ((d_q - lo_q) >> 1);
						stat_q <= lrb_pkg::ST_EXHAUSTED;
					end else if (is_high) begin
						lo_q   <= d_q;
						dist_q <= d_q + ((hi_q - d_q) >> 1);
						d_q    <= d_q + ((hi_q - d_q) >> 1);
						stat_q <= lrb_pkg::ST_EXHAUSTED;
					end else begin
						dist_q <= d_q;
						stat_q <= lrb_pkg::ST_CONVERGED;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
	assign status    = stat_q;

endmodule

@@ tb/lrb_checker.sv @@
// Checker for the light range bisection block: predicts each result and compares.
`timescale 1ns / 100ps
module lrb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [16:0] target_level,
	input  logic [16:0] accuracy,
	input  logic [23:0] const_coeff,
	input  logic [23:0] linear_coeff,
	input  logic [23:0] quad_coeff,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] distance,
	input  logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          range_seen,
	output int          status_seen [3]
);

	localparam int LF = 16;
	localparam logic [55:0] DEN_SAT = {56{1'b1}};

	typedef struct packed {
		logic [23:0] dval;
		logic [1:0]  stat;
	} range_word_t;

	range_word_t range_q[$];
	logic [6:0]  iter_lim;
	logic [23:0] far_lim;
	logic [15:0] thr_lim;

	// Attenuation denominator with saturation at 56 bits
	function automatic logic [55:0] atten_den(logic [63:0] d, logic [63:0] c,
		logic [63:0] l, logic [63:0] q);
		logic [63:0] d2, quad, sum;
		d2   = d * d;
		quad = q * (d2 >> 20) + ((q * (d2 & 64'hFFFFF)) >> 20);
		sum  = c + ((l * d) >> 10);
		if (sum > 64'(DEN_SAT)) sum = 64'(DEN_SAT);
		sum = sum + quad;
		if (sum > 64'(DEN_SAT)) sum = 64'(DEN_SAT);
		return sum[55:0];
	endfunction

	function automatic logic [63:0] light_level(logic [63:0] d, logic [63:0] c,
		logic [63:0] l, logic [63:0] q, logic [63:0] thr);
		logic [63:0] den, lvl;
		den = 64'(atten_den(d, c, l, q));
		if (den <= thr) return 64'd1 << LF;
		lvl = (64'd1 << (LF + 16)) / den;
		return (lvl > (64'd1 << LF)) ? (64'd1 << LF) : lvl;
	endfunction

	function automatic range_word_t find_range(logic [16:0] tgt, logic [16:0] acc_in,
		logic [23:0] c, logic [23:0] l, logic [23:0] q);
		range_word_t r;
		logic [63:0] acc, lo, hi, mid, lvl;
		longint band_lo, band_hi;
		acc = 64'(acc_in);
		if (tgt != 0 && acc >= 64'(tgt)) acc = 64'(tgt) / 64'd10;
		band_lo = longint'(tgt) - longint'(acc);
		band_hi = longint'(tgt) + longint'(acc);
		if (longint'(light_level(64'(far_lim), 64'(c), 64'(l), 64'(q), acc)) > band_hi) begin
			r.dval = far_lim;
			r.stat = lrb_pkg::ST_BEYOND;
			return r;
		end
		lo = '0;
		hi = 64'(far_lim);
		for (int n = 0; n < int'(iter_lim); n++) begin
			mid = lo + ((hi - lo) >> 1);
			lvl = light_level(mid, 64'(c), 64'(l), 64'(q), 64'(thr_lim));
			if (longint'(lvl) < band_lo)
				hi = mid;
			else if (longint'(lvl) > band_hi)
				lo = mid;
			else begin
				r.dval = mid[23:0];
				r.stat = lrb_pkg::ST_CONVERGED;
				return r;
			end
		end
		mid    = lo + ((hi - lo) >> 1);
		r.dval = mid[23:0];
		r.stat = lrb_pkg::ST_EXHAUSTED;
		return r;
	endfunction

	assign pending = range_q.size();

	// Track registers, predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		range_word_t exp_w;
		if (!arst_n) begin
			iter_lim   <= 7'd32;
			far_lim    <= 24'd10240000;
			thr_lim    <= 16'd7;
			fail_count <= 0;
			range_seen <= 0;
			for (int i = 0; i < 3; i++) status_seen[i] <= 0;
			range_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lrb_pkg::REG_MAX_ITER: iter_lim <= cfg_data[6:0];
					lrb_pkg::REG_FAR:      far_lim  <= cfg_data;
					lrb_pkg::REG_THR:      thr_lim  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				range_q.push_back(find_range(target_level, accuracy, const_coeff,
					linear_coeff, quad_coeff));
			if (out_valid && out_ready) begin
				range_seen <= range_seen + 1;
				if (status < 3) status_seen[status] <= status_seen[status] + 1;
				if (range_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected word: distance %0d status %0d", distance, status);
				end else begin
					exp_w = range_q.pop_front();
					if (exp_w.dval !== distance || exp_w.stat !== status) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: distance exp %0d got %0d, status exp %0d got %0d",
								exp_w.dval, distance, exp_w.stat, status);
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: stimulus, configuration phases and verdict for light_range_bisection.
`timescale 1ns / 100ps
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [16:0] target_level = '0;
	logic [16:0] accuracy = '0;
	logic [23:0] const_coeff = '0;
	logic [23:0] linear_coeff = '0;
	logic [23:0] quad_coeff = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] distance;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = lrb_pkg::REG_MAX_ITER;
	logic [23:0] cfg_data = '0;
	int          fail_count, pending, range_seen;
	int          status_seen [3];
	int          stall_cnt;
	bit          calm;
	bit          timed_out;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	light_range_bisection dut (.*);

	lrb_checker chk (.*);

	// Receiver stalls about 8% of cycles except in the calm stretch
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 8);

	// Watchdog: cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > 40000) begin
			$display("watchdog expired");
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_light(logic [16:0] t, logic [16:0] a,
		logic [23:0] c, logic [23:0] l, logic [23:0] q);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 8) @(negedge clk);
		in_valid     <= 1'b1;
		target_level <= t;
		accuracy     <= a;
		const_coeff  <= c;
		linear_coeff <= l;
		quad_coeff   <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Mostly physical coefficients so the search goes deep; some full-range noise
	task automatic send_random;
		logic [16:0] t, a;
		logic [23:0] c, l, q;
		if ($urandom_range(9) < 8) begin
			t = 17'($urandom_range(65536, 1));
			a = ($urandom_range(3) == 0) ? 17'($urandom_range(65536))
			                             : 17'($urandom_range(32'(t >> 3)));
			c = 24'($urandom_range(65536));
			l = 24'($urandom_range(65536));
			q = 24'($urandom_range(4096));
		end else begin
			t = 17'($urandom_range(131071));
			a = 17'($urandom_range(131071));
			c = 24'($urandom_range(24'hFFFFFF));
			l = 24'($urandom_range(24'hFFFFFF));
			q = 24'($urandom_range(24'hFFFFFF));
		end
		send_light(t, a, c, l, q);
	endtask

	initial begin
		calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes and special cases at reset settings
		send_light(17'd0, 17'd0, 24'd0, 24'd0, 24'd0);
		send_light(17'd65536, 17'd65536, 24'd65536, 24'd0, 24'd0);
		send_light(17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_light(17'd100, 17'd5, 24'd65536, 24'd0, 24'd0);
		send_light(17'd32768, 17'd100, 24'd65536, 24'd6554, 24'd655);
		send_light(17'd655, 17'd65, 24'd65536, 24'd0, 24'd66);
		send_light(17'd1, 17'd0, 24'd0, 24'd0, 24'd1);
		send_light(17'd50000, 17'd0, 24'd65536, 24'd65536, 24'd65536);
		send_light(17'd0, 17'h10000, 24'd3, 24'd0, 24'd0);
		send_light(17'd1000, 17'd2000, 24'd0, 24'd655, 24'd0);
		drain();
		// Extreme settings
		write_reg(lrb_pkg::REG_MAX_ITER, 24'd0);
		write_reg(lrb_pkg::REG_FAR, 24'd1);
		write_reg(lrb_pkg::REG_THR, 24'd0);
		send_light(17'd30000, 17'd10, 24'd65536, 24'd65536, 24'd100);
		send_light(17'd1, 17'd0, 24'd0, 24'd0, 24'd0);
		drain();
		write_reg(lrb_pkg::REG_MAX_ITER, 24'd127);
		write_reg(lrb_pkg::REG_FAR, 24'hFFFFFF);
		write_reg(lrb_pkg::REG_THR, 24'hFFFF);
		send_light(17'd1, 17'd0, 24'd65536, 24'd65536, 24'd1);
		send_light(17'd10000, 17'd0, 24'd65536, 24'd6554, 24'd655);
		send_light(17'd65536, 17'd0, 24'd0, 24'd0, 24'd0);
		drain();

		// Random phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(lrb_pkg::REG_MAX_ITER,
				ph == 0 ? 24'd64 : 24'($urandom_range(64)));
			write_reg(lrb_pkg::REG_FAR,
				ph == 1 ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF, 1)));
			write_reg(lrb_pkg::REG_THR,
				ph == 2 ? 24'd0 : 24'($urandom_range(65535)));
			calm = (ph == 3);
			for (int i = 0; i < 200; i++) send_random();
			drain();
		end
		calm = 1'b0;

		$display("ran %0d ranges: %0d converged, %0d beyond far limit, %0d exhausted",
			range_seen, status_seen[0], status_seen[1], status_seen[2]);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lrb_pkg.sv
rtl/lrb_mul.sv
rtl/lrb_div.sv
rtl/light_range_bisection.sv
tb/lrb_checker.sv
tb/tb_top.sv
